@@ rtl/msp_pkg.sv @@
// MIDI stream parser package: message kinds, result and command records,
// status byte constants and the message length decode.
// No dependencies.
package msp_pkg;

    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_EOX      = 8'hF7;
    localparam logic [7:0] ST_RT_MIN   = 8'hF8;
    localparam logic [7:0] ST_TUNE     = 8'hF6;
    localparam logic [7:0] ST_MTC      = 8'hF1;
    localparam logic [7:0] ST_SONG_SEL = 8'hF3;
    localparam logic [7:0] ST_SONG_POS = 8'hF2;
    localparam logic [7:0] ST_CH_MAX   = 8'hEF;
    localparam logic [7:0] ST_PROG     = 8'hC0;
    localparam logic [7:0] ST_CHPRES   = 8'hD0;
    localparam logic [7:0] STATUS_BIT  = 8'h80;
    localparam logic [7:0] HI_NIBBLE   = 8'hF0;
    localparam logic [6:0] DATA_MASK   = 7'h7F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CHAN   = 2'd1,
        KIND_SYSCOM = 2'd2,
        KIND_SYSEX  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] status;
        logic [1:0] msg_size;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [6:0] sysex_data;
        logic       sysex_data_valid;
        logic       sysex_truncated;
        logic       used_running;
        logic       malformed;
        logic       realtime_res;
        logic       last;
    } res_t;

    typedef struct packed {
        logic dump;
        res_t res;
    } cmd_t;

    function automatic logic [1:0] len_of(input logic [7:0] s);
        logic [7:0] hi;
        hi = s & HI_NIBBLE;
        if (s >= STATUS_BIT && s <= ST_CH_MAX) begin
            return (hi == ST_PROG || hi == ST_CHPRES) ? 2'd2 : 2'd3;
        end
        if (s == ST_MTC || s == ST_SONG_SEL) return 2'd2;
        if (s == ST_SONG_POS) return 2'd3;
        if (s == ST_TUNE) return 2'd1;
        return 2'd0;
    endfunction

endpackage

@@ rtl/msp_front.sv @@
// Front end of the MIDI stream parser: takes bytes, tracks running status and
// sysex state, writes sysex payload to the store and queues result commands.
// Depends on msp_pkg.
module msp_front #(
    parameter int SYSEX_DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    output logic                             push,
    output msp_pkg::cmd_t                    cmd,
    input  logic                             fifo_full,
    output logic                             wr_en,
    output logic [((SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1)-1:0] wr_addr,
    output logic [6:0]                       wr_data,
    output logic [$clog2(SYSEX_DEPTH + 1)-1:0] dump_len,
    input  logic                             dump_done
);
    import msp_pkg::*;

    localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
    localparam int CW = $clog2(SYSEX_DEPTH + 1);

    logic [7:0]    running_stat_reg, running_stat_next;
    logic [7:0]    cur_stat_reg, cur_stat_next;
    logic [1:0]    expect_len_reg, expect_len_next;
    logic [1:0]    have_len_reg, have_len_next;
    logic [6:0]    d0_reg, d0_next;
    logic [6:0]    d1_reg, d1_next;
    logic          running_flag_reg, running_flag_next;
    logic          in_sysex_reg, in_sysex_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg, busy_next;
    logic [CW-1:0] dump_len_reg, dump_len_next;

    logic          accept;
    logic          bad;
    logic          go;
    logic          ok;
    logic          emit_now;
    logic [1:0]    sz;

    assign s_ready  = !fifo_full && !busy_reg;
    assign accept   = s_valid && s_ready;
    assign dump_len = dump_len_reg;
    assign wr_data  = s_data_byte[6:0] & DATA_MASK;
    assign wr_addr  = count_reg[AW-1:0];

    always_comb begin
        running_stat_next = running_stat_reg;
        cur_stat_next     = cur_stat_reg;
        expect_len_next   = expect_len_reg;
        have_len_next     = have_len_reg;
        d0_next           = d0_reg;
        d1_next           = d1_reg;
        running_flag_next = running_flag_reg;
        in_sysex_next     = in_sysex_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        busy_next         = busy_reg;
        dump_len_next     = dump_len_reg;
        push              = 1'b0;
        cmd               = '0;
        wr_en             = 1'b0;
        bad               = 1'b0;
        go                = 1'b1;
        ok                = 1'b1;
        emit_now          = 1'b0;
        sz                = 2'd0;

        if (dump_done) begin
            busy_next = 1'b0;
        end

        if (accept) begin
            if (s_data_byte >= ST_RT_MIN) begin
                push                  = 1'b1;
                cmd.res.realtime_res  = 1'b1;
                cmd.res.last          = 1'b1;
            end else begin
                if (in_sysex_reg) begin
                    if (s_data_byte == ST_EOX) begin
                        go                      = 1'b0;
                        push                    = 1'b1;
                        cmd.res.kind            = KIND_SYSEX;
                        cmd.res.status          = ST_SYSEX;
                        cmd.res.sysex_truncated = ovf_reg;
                        if (count_reg == '0) begin
                            cmd.res.last = 1'b1;
                        end else begin
                            cmd.dump      = 1'b1;
                            busy_next     = 1'b1;
                            dump_len_next = count_reg;
                        end
                        in_sysex_next     = 1'b0;
                        count_next        = '0;
                        ovf_next          = 1'b0;
                        running_stat_next = '0;
                        cur_stat_next     = '0;
                        expect_len_next   = '0;
                        have_len_next     = '0;
                    end else if (s_data_byte[7]) begin
                        bad           = 1'b1;
                        in_sysex_next = 1'b0;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                    end else begin
                        go = 1'b0;
                        if (count_reg < CW'(SYSEX_DEPTH)) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end

                if (go) begin
                    if (s_data_byte[7]) begin
                        if (s_data_byte == ST_SYSEX) begin
                            in_sysex_next     = 1'b1;
                            count_next        = '0;
                            ovf_next          = 1'b0;
                            running_stat_next = '0;
                            cur_stat_next     = '0;
                            expect_len_next   = '0;
                            have_len_next     = '0;
                        end else if (s_data_byte == ST_EOX) begin
                            bad = 1'b1;
                        end else begin
                            sz = len_of(s_data_byte);
                            if (sz == 2'd0) begin
                                bad               = 1'b1;
                                running_stat_next = '0;
                            end else begin
                                cur_stat_next     = s_data_byte;
                                expect_len_next   = sz;
                                have_len_next     = 2'd1;
                                running_flag_next = 1'b0;
                                running_stat_next = (s_data_byte < ST_SYSEX) ? s_data_byte : '0;
                                emit_now          = (sz == 2'd1);
                            end
                        end
                    end else begin
                        if (have_len_next == 2'd0) begin
                            if (running_stat_next == '0) begin
                                ok = 1'b0;
                            end else begin
                                cur_stat_next     = running_stat_next;
                                expect_len_next   = len_of(running_stat_next);
                                have_len_next     = 2'd1;
                                running_flag_next = 1'b1;
                            end
                        end
                        if (ok && (have_len_next >= expect_len_next || have_len_next == 2'd0)) begin
                            ok = 1'b0;
                        end
                        if (ok) begin
                            if (have_len_next == 2'd1) begin
                                d0_next = s_data_byte[6:0];
                            end else begin
                                d1_next = s_data_byte[6:0];
                            end
                            have_len_next = have_len_next + 2'd1;
                            emit_now      = 1'b1;
                        end else begin
                            bad = 1'b1;
                        end
                    end

                    if (emit_now && expect_len_next != 2'd0
                            && have_len_next == expect_len_next) begin
                        push                 = 1'b1;
                        cmd.res.kind         = (cur_stat_next < ST_SYSEX) ? KIND_CHAN : KIND_SYSCOM;
                        cmd.res.status       = cur_stat_next;
                        cmd.res.msg_size     = expect_len_next;
                        cmd.res.first_data   = (expect_len_next >= 2'd2) ? d0_next : '0;
                        cmd.res.second_data  = (expect_len_next >= 2'd3) ? d1_next : '0;
                        cmd.res.used_running = (cur_stat_next < ST_SYSEX) && running_flag_next;
                        cmd.res.malformed    = bad;
                        cmd.res.last         = 1'b1;
                        have_len_next        = '0;
                        expect_len_next      = '0;
                        cur_stat_next        = '0;
                        running_flag_next    = 1'b0;
                    end
                end

                if (!push && bad) begin
                    push              = 1'b1;
                    cmd.res.malformed = 1'b1;
                    cmd.res.last      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_stat_reg <= '0;
            cur_stat_reg     <= '0;
            expect_len_reg   <= '0;
            have_len_reg     <= '0;
            d0_reg           <= '0;
            d1_reg           <= '0;
            running_flag_reg <= 1'b0;
            in_sysex_reg     <= 1'b0;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            busy_reg         <= 1'b0;
            dump_len_reg     <= '0;
        end else begin
            running_stat_reg <= running_stat_next;
            cur_stat_reg     <= cur_stat_next;
            expect_len_reg   <= expect_len_next;
            have_len_reg     <= have_len_next;
            d0_reg           <= d0_next;
            d1_reg           <= d1_next;
            running_flag_reg <= running_flag_next;
            in_sysex_reg     <= in_sysex_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            busy_reg         <= busy_next;
            dump_len_reg     <= dump_len_next;
        end
    end

    a_no_write_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !busy_reg)
        else $error("sysex store written while a run is read out");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_full)
        else $error("command pushed into a full queue");

    a_sysex_no_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        in_sysex_reg |-> (expect_len_reg == 2'd0 && have_len_reg == 2'd0))
        else $error("short message pending inside a sysex");

endmodule

@@ rtl/msp_cmd_fifo.sv @@
// Command queue between the parser front end and the result back end.
// Depends on msp_pkg.
module msp_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  msp_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output msp_pkg::cmd_t cmd_out,
    output logic          empty
);
    import msp_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign cmd_out = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/msp_back.sv @@
// Back end of the MIDI stream parser: holds the sysex store, expands sysex
// runs into results and drives the result output register.
// Depends on msp_pkg.
module msp_back #(
    parameter int SYSEX_DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  msp_pkg::cmd_t                    fifo_cmd,
    input  logic                             fifo_empty,
    output logic                             fifo_pop,
    input  logic                             wr_en,
    input  logic [((SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1)-1:0] wr_addr,
    input  logic [6:0]                       wr_data,
    input  logic [$clog2(SYSEX_DEPTH + 1)-1:0] dump_len,
    output logic                             dump_done,
    output logic                             m_valid,
    input  logic                             m_ready,
    output msp_pkg::res_t                    m_res
);
    import msp_pkg::*;

    localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
    localparam int CW = $clog2(SYSEX_DEPTH + 1);

    logic [6:0]    mem [SYSEX_DEPTH];

    logic          dumping_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] len_reg;
    logic          trunc_reg;
    logic          rd_valid_reg;
    logic          rd_last_reg;
    logic [6:0]    rd_data_reg;
    logic          out_valid_reg;
    res_t          out_reg;

    logic          out_free;
    logic          rd_move;
    logic          rd_go;
    logic          rd_end;
    logic          pop_dump;
    logic          pop_direct;
    res_t          sx_res;

    always_comb begin
        out_free   = !out_valid_reg || m_ready;
        rd_move    = rd_valid_reg && out_free;
        rd_go      = dumping_reg && (!rd_valid_reg || rd_move);
        rd_end     = rd_go && (idx_reg == len_reg - CW'(1));
        pop_dump   = !fifo_empty && !dumping_reg && !rd_valid_reg && fifo_cmd.dump;
        pop_direct = !fifo_empty && !dumping_reg && !fifo_cmd.dump
                     && !rd_valid_reg && out_free;
        fifo_pop   = pop_dump || pop_direct;
        dump_done  = rd_end;

        sx_res                  = '0;
        sx_res.kind             = KIND_SYSEX;
        sx_res.status           = ST_SYSEX;
        sx_res.sysex_data       = rd_data_reg;
        sx_res.sysex_data_valid = 1'b1;
        sx_res.sysex_truncated  = trunc_reg;
        sx_res.last             = rd_last_reg;
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_go) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_move) begin
            out_reg <= sx_res;
        end else if (pop_direct) begin
            out_reg <= fifo_cmd.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dumping_reg   <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
            trunc_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop_dump) begin
                dumping_reg <= 1'b1;
                idx_reg     <= '0;
                len_reg     <= dump_len;
                trunc_reg   <= fifo_cmd.res.sysex_truncated;
            end else if (rd_go) begin
                idx_reg <= idx_reg + CW'(1);
                if (rd_end) begin
                    dumping_reg <= 1'b0;
                end
            end
            if (rd_go) begin
                rd_valid_reg <= 1'b1;
                rd_last_reg  <= rd_end;
            end else if (rd_move) begin
                rd_valid_reg <= 1'b0;
            end
            if (rd_move || pop_direct) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        dumping_reg |-> (idx_reg < len_reg))
        else $error("sysex read index past run length");

    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        dump_done |=> (!dumping_reg && rd_valid_reg && rd_last_reg))
        else $error("sysex run did not close on its last byte");

    a_no_direct_during_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (dumping_reg || rd_valid_reg) |-> !pop_direct)
        else $error("short result overtook a sysex run");

endmodule

@@ rtl/midi_stream_parser_unit.sv @@
// MIDI stream parser top level: front end, command queue and back end.
// Depends on msp_pkg, msp_front, msp_cmd_fifo and msp_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | s_valid / s_ready  | s_data_byte
//   result   | m_valid / m_ready  | m_kind .. m_last, one port per field
//
// A byte is parsed in the cycle it is accepted; a short result reaches m_valid
// through the command queue and the output register.
// A sysex run reads the store at one entry per cycle while m_ready stays high;
// after an EOX that closes a run of stored bytes, s_ready stays low until the
// last of them is read, which takes longer if m_ready stalls or results wait
// ahead of the run. The input also stalls when the command queue is full.
// Reset is synchronous, active low; the store needs no clearing pass.
module midi_stream_parser_unit #(
    parameter int SYSEX_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_status,
    output logic [1:0] m_msg_size,
    output logic [6:0] m_first_data,
    output logic [6:0] m_second_data,
    output logic [6:0] m_sysex_data,
    output logic       m_sysex_data_valid,
    output logic       m_sysex_truncated,
    output logic       m_used_running,
    output logic       m_malformed,
    output logic       m_realtime_res,
    output logic       m_last
);
    import msp_pkg::*;

    localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
    localparam int CW = $clog2(SYSEX_DEPTH + 1);

    cmd_t          push_cmd;
    cmd_t          head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [6:0]    wr_data;
    logic [CW-1:0] dump_len;
    logic          dump_done;
    res_t          res;

    msp_front #(
        .SYSEX_DEPTH(SYSEX_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_byte(s_data_byte),
        .push       (push),
        .cmd        (push_cmd),
        .fifo_full  (full),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .dump_len   (dump_len),
        .dump_done  (dump_done)
    );

    msp_cmd_fifo u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .cmd_in (push_cmd),
        .full   (full),
        .pop    (pop),
        .cmd_out(head_cmd),
        .empty  (empty)
    );

    msp_back #(
        .SYSEX_DEPTH(SYSEX_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fifo_cmd  (head_cmd),
        .fifo_empty(empty),
        .fifo_pop  (pop),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .dump_len  (dump_len),
        .dump_done (dump_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (res)
    );

    assign m_kind             = res.kind;
    assign m_status           = res.status;
    assign m_msg_size         = res.msg_size;
    assign m_first_data       = res.first_data;
    assign m_second_data      = res.second_data;
    assign m_sysex_data       = res.sysex_data;
    assign m_sysex_data_valid = res.sysex_data_valid;
    assign m_sysex_truncated  = res.sysex_truncated;
    assign m_used_running     = res.used_running;
    assign m_malformed        = res.malformed;
    assign m_realtime_res     = res.realtime_res;
    assign m_last             = res.last;

endmodule

@@ tb/midi_msg_checker.sv @@
// Result checker for midi_stream_parser_unit: watches both channels, predicts
// each result from the accepted bytes and compares against the result channel.
// Depends on msp_pkg.
module midi_msg_checker #(
    parameter int SYSEX_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_kind,
    input  logic [7:0] m_status,
    input  logic [1:0] m_msg_size,
    input  logic [6:0] m_first_data,
    input  logic [6:0] m_second_data,
    input  logic [6:0] m_sysex_data,
    input  logic       m_sysex_data_valid,
    input  logic       m_sysex_truncated,
    input  logic       m_used_running,
    input  logic       m_malformed,
    input  logic       m_realtime_res,
    input  logic       m_last,
    output int         fail_count,
    output int         outstanding,
    output int         results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import msp_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic [7:0] run_status;
    logic [7:0] pend_status;
    int         need_len;
    int         got_len;
    logic [6:0] data_hold [2];
    logic       from_running;
    logic       in_sysex;
    logic       sx_over;
    logic [6:0] sx_store [SYSEX_DEPTH];
    int         sx_count;
    res_t       expected_msgs [$];

    function automatic int msg_len(input logic [7:0] s);
        if (s >= STATUS_BIT && s <= ST_CH_MAX) begin
            return (s[7:5] == 3'b110) ? 2 : 3;
        end
        if (s == ST_MTC || s == ST_SONG_SEL) return 2;
        if (s == ST_SONG_POS) return 3;
        if (s == ST_TUNE) return 1;
        return 0;
    endfunction

    function automatic string fmt_msg(input res_t r);
        return $sformatf({"kind %0d status %02h size %0d data %02h %02h sysex %02h",
                          " valid %0b trunc %0b running %0b malformed %0b rt %0b last %0b"},
                         r.kind, r.status, r.msg_size, r.first_data, r.second_data,
                         r.sysex_data, r.sysex_data_valid, r.sysex_truncated,
                         r.used_running, r.malformed, r.realtime_res, r.last);
    endfunction

    task automatic add_expected(input res_t r);
        expected_msgs.insert(expected_msgs.size(), r);
    endtask

    task automatic clear_msg();
        run_status  = 8'h00;
        pend_status = 8'h00;
        need_len    = 0;
        got_len     = 0;
    endtask

    task automatic close_msg(input logic bad, output int n);
        res_t r;
        n = 0;
        if (need_len == 0 || got_len != need_len) return;
        r = '0;
        r.kind = (pend_status < ST_SYSEX) ? KIND_CHAN : KIND_SYSCOM;
        r.status = pend_status;
        r.msg_size = 2'(need_len);
        if (need_len >= 2) r.first_data = data_hold[0];
        if (need_len >= 3) r.second_data = data_hold[1];
        r.used_running = (pend_status < ST_SYSEX) && from_running;
        r.malformed = bad;
        r.last = 1'b1;
        add_expected(r);
        got_len      = 0;
        need_len     = 0;
        pend_status  = 8'h00;
        from_running = 1'b0;
        n = 1;
    endtask

    task automatic parse_midi_byte(input logic [7:0] b);
        res_t r;
        logic bad;
        logic ok;
        int   n;
        int   sz;
        int   i;
        bad = 1'b0;
        n = 0;
        if (b >= ST_RT_MIN) begin
            r = '0;
            r.realtime_res = 1'b1;
            r.last = 1'b1;
            add_expected(r);
            return;
        end
        if (in_sysex) begin
            if (b == ST_EOX) begin
                if (sx_count == 0) begin
                    r = '0;
                    r.kind = KIND_SYSEX;
                    r.status = ST_SYSEX;
                    r.sysex_truncated = sx_over;
                    r.last = 1'b1;
                    add_expected(r);
                end else begin
                    for (i = 0; i < sx_count; i++) begin
                        r = '0;
                        r.kind = KIND_SYSEX;
                        r.status = ST_SYSEX;
                        r.sysex_data = sx_store[i];
                        r.sysex_data_valid = 1'b1;
                        r.sysex_truncated = sx_over;
                        r.last = (i == sx_count - 1);
                        add_expected(r);
                    end
                end
                in_sysex = 1'b0;
                sx_count = 0;
                sx_over  = 1'b0;
                clear_msg();
                return;
            end
            if (b[7]) begin
                bad      = 1'b1;
                in_sysex = 1'b0;
                sx_count = 0;
                sx_over  = 1'b0;
            end else begin
                if (sx_count < SYSEX_DEPTH) begin
                    sx_store[sx_count] = b[6:0];
                    sx_count++;
                end else begin
                    sx_over = 1'b1;
                end
                return;
            end
        end
        if (b[7]) begin
            if (b == ST_SYSEX) begin
                in_sysex = 1'b1;
                sx_count = 0;
                sx_over  = 1'b0;
                clear_msg();
            end else if (b == ST_EOX) begin
                bad = 1'b1;
            end else begin
                sz = msg_len(b);
                if (sz == 0) begin
                    bad = 1'b1;
                    run_status = 8'h00;
                end else begin
                    pend_status  = b;
                    need_len     = sz;
                    got_len      = 1;
                    from_running = 1'b0;
                    run_status   = (b < ST_SYSEX) ? b : 8'h00;
                    if (sz == 1) close_msg(bad, n);
                end
            end
        end else begin
            ok = 1'b1;
            if (got_len == 0) begin
                if (run_status == 8'h00) begin
                    ok = 1'b0;
                end else begin
                    pend_status  = run_status;
                    need_len     = msg_len(run_status);
                    got_len      = 1;
                    from_running = 1'b1;
                end
            end
            if (ok && (got_len >= need_len || got_len == 0)) ok = 1'b0;
            if (ok) begin
                data_hold[(got_len - 1) % 2] = b[6:0];
                got_len++;
                if (got_len == need_len) close_msg(1'b0, n);
            end else begin
                bad = 1'b1;
            end
        end
        if (n == 0 && bad) begin
            r = '0;
            r.malformed = 1'b1;
            r.last = 1'b1;
            add_expected(r);
        end
    endtask

    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        if (!aresetn) begin
            in_sysex     = 1'b0;
            sx_count     = 0;
            sx_over      = 1'b0;
            from_running = 1'b0;
            data_hold[0] = 7'h00;
            data_hold[1] = 7'h00;
            clear_msg();
            expected_msgs.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.kind             = kind_t'(m_kind);
                got.status           = m_status;
                got.msg_size         = m_msg_size;
                got.first_data       = m_first_data;
                got.second_data      = m_second_data;
                got.sysex_data       = m_sysex_data;
                got.sysex_data_valid = m_sysex_data_valid;
                got.sysex_truncated  = m_sysex_truncated;
                got.used_running     = m_used_running;
                got.malformed        = m_malformed;
                got.realtime_res     = m_realtime_res;
                got.last             = m_last;
                results_seen++;
                if (expected_msgs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected result at %0t: %s", $realtime, fmt_msg(got));
                    end
                end else begin
                    want = expected_msgs[0];
                    expected_msgs.delete(0);
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", fmt_msg(want));
                            $display("  actual   %s", fmt_msg(got));
                        end
                    end
                end
            end
            if (s_valid && s_ready) parse_midi_byte(s_data_byte);
        end
        outstanding = expected_msgs.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top level testbench for midi_stream_parser_unit: clock, reset, byte stimulus
// and result-side stalls; checking is done by midi_msg_checker.
// Depends on msp_pkg, midi_msg_checker and the parser RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import msp_pkg::*;

    localparam int         RANDOM_BEATS = 230;
    localparam int         CALM_BEATS   = 40;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam logic [7:0] UNDEF_F4     = 8'hF4;
    localparam logic [7:0] UNDEF_F5     = 8'hF5;
    localparam logic [7:0] RT_MAX       = 8'hFF;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_status;
    logic [1:0] m_msg_size;
    logic [6:0] m_first_data;
    logic [6:0] m_second_data;
    logic [6:0] m_sysex_data;
    logic       m_sysex_data_valid;
    logic       m_sysex_truncated;
    logic       m_used_running;
    logic       m_malformed;
    logic       m_realtime_res;
    logic       m_last;

    int   fail_count;
    int   outstanding;
    int   results_seen;
    int   beats_sent;
    int   sysex_frames;
    int   idle_rate;
    int   cycles;
    logic calm;

    midi_stream_parser_unit i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_status           (m_status),
        .m_msg_size         (m_msg_size),
        .m_first_data       (m_first_data),
        .m_second_data      (m_second_data),
        .m_sysex_data       (m_sysex_data),
        .m_sysex_data_valid (m_sysex_data_valid),
        .m_sysex_truncated  (m_sysex_truncated),
        .m_used_running     (m_used_running),
        .m_malformed        (m_malformed),
        .m_realtime_res     (m_realtime_res),
        .m_last             (m_last)
    );

    midi_msg_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_status           (m_status),
        .m_msg_size         (m_msg_size),
        .m_first_data       (m_first_data),
        .m_second_data      (m_second_data),
        .m_sysex_data       (m_sysex_data),
        .m_sysex_data_valid (m_sysex_data_valid),
        .m_sysex_truncated  (m_sysex_truncated),
        .m_used_running     (m_used_running),
        .m_malformed        (m_malformed),
        .m_realtime_res     (m_realtime_res),
        .m_last             (m_last),
        .fail_count         (fail_count),
        .outstanding        (outstanding),
        .results_seen       (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        idle_rate = 25;
        forever begin
            repeat (50) @(posedge aclk);
            case ($urandom_range(0, 2))
                0: idle_rate = 0;
                1: idle_rate = 15;
                default: idle_rate = 40;
            endcase
        end
    end

    initial begin
        int stall_left;
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < idle_rate) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("midi_stream_parser_unit verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < idle_rate) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    task automatic send_data();
        send_byte(8'($urandom_range(0, 127)));
    endtask

    task automatic send_random_message();
        int         pick;
        int         len;
        int         i;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            st = 8'($urandom_range(STATUS_BIT, ST_CH_MAX));
            send_byte(st);
            send_data();
            if (st[7:5] != 3'b110) send_data();
        end else if (pick < 45) begin
            send_data();
            if ($urandom_range(0, 1) == 1) send_data();
        end else if (pick < 57) begin
            case ($urandom_range(0, 3))
                0: begin
                    send_byte(ST_MTC);
                    send_data();
                end
                1: begin
                    send_byte(ST_SONG_SEL);
                    send_data();
                end
                2: begin
                    send_byte(ST_SONG_POS);
                    send_data();
                    send_data();
                end
                default: send_byte(ST_TUNE);
            endcase
        end else if (pick < 75) begin
            len = ($urandom_range(0, 14) == 0) ? $urandom_range(62, 70) : $urandom_range(0, 8);
            sysex_frames++;
            send_byte(ST_SYSEX);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(ST_RT_MIN, RT_MAX)));
                send_data();
            end
            if ($urandom_range(0, 99) < 85) send_byte(ST_EOX);
            else send_byte(8'($urandom_range(STATUS_BIT, ST_TUNE)));
        end else if (pick < 85) begin
            send_byte(8'($urandom_range(ST_RT_MIN, RT_MAX)));
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0] directed_bytes [$];
        int         directed_count;
        int         random_start;
        logic       paused;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = 8'h00;
        calm         = 1'b0;
        beats_sent   = 0;
        sysex_frames = 0;
        paused       = 1'b0;
        directed_bytes = '{8'h00,
                           8'h80, 8'h00, 8'h7F,
                           8'h7F, 8'h00,
                           8'hDF, 8'h40,
                           ST_MTC, 8'h55,
                           8'h22,
                           ST_SONG_POS, 8'h01, UNDEF_F4, 8'h02,
                           ST_TUNE,
                           UNDEF_F5, ST_EOX,
                           RT_MAX,
                           ST_SYSEX, ST_EOX,
                           ST_SYSEX, 8'h01, ST_RT_MIN, 8'h7E, ST_EOX,
                           ST_SYSEX, 8'h11, ST_TUNE};
        directed_count = directed_bytes.size();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
        sysex_frames += 3;
        wait_drained();

        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            if (beats_sent - random_start >= RANDOM_BEATS - CALM_BEATS) calm = 1'b1;
            if (!paused && beats_sent - random_start >= RANDOM_BEATS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            send_random_message();
        end
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("covered %0d input beats (%0d directed) including %0d sysex frames",
                 beats_sent, directed_count, sysex_frames);
        $display("compared %0d results, %0d mismatched", results_seen, fail_count);
        if (fail_count == 0) begin
            $display("midi_stream_parser_unit verification clean");
        end else begin
            $display("midi_stream_parser_unit verification failed");
        end
        $finish;
    end

endmodule
